### rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

    // Width of the vertex slot field and of the vertex count register.
    localparam int IDX_W   = 6;
    localparam int COUNT_W = 7;

    // Field width of the coordinate ports.
    localparam int PORT_COORD_W = 32;

    // Slots that the vertex_index field can reach.
    localparam int SLOTS = 64;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_WRAP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Running crossing status reported by the edge unit.
    typedef struct packed {
        logic hit;
        logic right_odd;
        logic left_odd;
    } edge_status_t;

endpackage

### rtl/pip_cell.sv
// ----------------------------------------------------------------------------
// pip_cell
// One vertex cell of the rotating ring: holds a vertex and takes its
// neighbor's vertex on every shift.
// ----------------------------------------------------------------------------
module pip_cell #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                load_en,
    input  logic signed [W-1:0] load_x,
    input  logic signed [W-1:0] load_y,
    input  logic                shift_en,
    input  logic signed [W-1:0] next_x,
    input  logic signed [W-1:0] next_y,
    output logic signed [W-1:0] x,
    output logic signed [W-1:0] y
);

    logic signed [W-1:0] x_reg, x_next;
    logic signed [W-1:0] y_reg, y_next;

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        if (load_en)
        begin
            x_next = load_x;
            y_next = load_y;
        end
        else if (shift_en)
        begin
            x_next = next_x;
            y_next = next_y;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

### rtl/pip_bbox.sv
// ----------------------------------------------------------------------------
// pip_bbox
// Running bounding box of the loaded vertices and the box test of a query.
// ----------------------------------------------------------------------------
module pip_bbox #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load_en,
    input  logic                load_first,
    input  logic signed [W-1:0] pt_x,
    input  logic signed [W-1:0] pt_y,
    output logic                inbox
);

    localparam logic signed [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0] min_x_reg, min_x_next;
    logic signed [W-1:0] min_y_reg, min_y_next;
    logic signed [W-1:0] max_x_reg, max_x_next;
    logic signed [W-1:0] max_y_reg, max_y_next;

    always_comb
    begin
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (load_en)
        begin
            // Slot 0 restarts the box; later slots only widen it.
            if (load_first)
            begin
                min_x_next = pt_x;
                max_x_next = pt_x;
                min_y_next = pt_y;
                max_y_next = pt_y;
            end
            else
            begin
                if (pt_x < min_x_reg) min_x_next = pt_x;
                if (pt_x > max_x_reg) max_x_next = pt_x;
                if (pt_y < min_y_reg) min_y_next = pt_y;
                if (pt_y > max_y_reg) max_y_next = pt_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= MOST_POS;
            min_y_reg <= MOST_POS;
            max_x_reg <= MOST_NEG;
            max_y_reg <= MOST_NEG;
        end
        else
        begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    // Strict at the minimum edges, inclusive at the maximum edges.
    assign inbox = (pt_x > min_x_reg) && (pt_x <= max_x_reg) &&
                   (pt_y > min_y_reg) && (pt_y <= max_y_reg);

endmodule

### rtl/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Three-stage edge evaluator: differences, cross products, then the exact
// sign test and the crossing parity update.
// ----------------------------------------------------------------------------
module pip_edge_unit #(
    parameter int W = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  clear,
    input  logic                  edge_valid,
    input  logic signed [W-1:0]   prev_x,
    input  logic signed [W-1:0]   prev_y,
    input  logic signed [W-1:0]   cur_x,
    input  logic signed [W-1:0]   cur_y,
    input  logic signed [W-1:0]   query_x,
    input  logic signed [W-1:0]   query_y,
    output logic                  busy,
    output pip_pkg::edge_status_t status
);

    localparam int D = W + 1;
    localparam int P = 2 * D;

    // Stage 1: offsets from the query point.
    logic                s1_valid_reg;
    logic signed [D-1:0] dxi_reg, dyi_reg, dxj_reg, dyj_reg;
    logic                den_pos_s1_reg;

    // Stage 2: products and crossing flags.
    logic                s2_valid_reg;
    logic signed [P-1:0] p_reg, q_reg;
    logic                hit_s2_reg, cr_right_reg, cr_left_reg, den_pos_s2_reg;

    // Accumulated status.
    pip_pkg::edge_status_t status_reg, status_next;

    logic signed [P:0]   diff;
    logic                s_zero, s_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= edge_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dxi_reg        <= $signed({cur_x[W-1], cur_x}) - $signed({query_x[W-1], query_x});
        dyi_reg        <= $signed({cur_y[W-1], cur_y}) - $signed({query_y[W-1], query_y});
        dxj_reg        <= $signed({prev_x[W-1], prev_x}) - $signed({query_x[W-1], query_x});
        dyj_reg        <= $signed({prev_y[W-1], prev_y}) - $signed({query_y[W-1], query_y});
        den_pos_s1_reg <= prev_y > cur_y;

        p_reg          <= dxi_reg * dyj_reg;
        q_reg          <= dxj_reg * dyi_reg;
        hit_s2_reg     <= (dxi_reg == '0) && (dyi_reg == '0);
        cr_right_reg   <= (dyi_reg > 0) != (dyj_reg > 0);
        cr_left_reg    <= (dyi_reg < 0) != (dyj_reg < 0);
        den_pos_s2_reg <= den_pos_s1_reg;
    end

    assign diff   = $signed({p_reg[P-1], p_reg}) - $signed({q_reg[P-1], q_reg});
    assign s_zero = (diff == '0);
    assign s_pos  = !diff[P] && !s_zero;

    always_comb
    begin
        status_next = status_reg;
        if (clear)
        begin
            status_next = '0;
        end
        else if (s2_valid_reg)
        begin
            status_next.hit = status_reg.hit | hit_s2_reg;
            if (cr_right_reg && !s_zero && (s_pos == den_pos_s2_reg))
                status_next.right_odd = !status_reg.right_odd;
            if (cr_left_reg && !s_zero && (s_pos != den_pos_s2_reg))
                status_next.left_odd = !status_reg.left_odd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            status_reg <= '0;
        else
            status_reg <= status_next;
    end

    assign busy   = s1_valid_reg | s2_valid_reg;
    assign status = status_reg;

endmodule

### rtl/point_in_polygon_test_top.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_top
// Ray-crossing point-in-polygon test over a rotating ring of vertex cells.
//
//   channel | dir | signals                                   | transfer when
//   --------+-----+-------------------------------------------+-----------------
//   in      | in  | action, vertex_index, x_coord, y_coord    | in_valid & in_ready
//   out     | out | inside_res                                | out_valid & out_ready
//   cfg     | in  | cfg_wr_data (vertex_count)                | cfg_wr_en
//
// A query outside the bounding box, or with a vertex count of zero, goes
// straight to the finish state. A query inside the box rotates the ring once
// through min(MAX_VERTICES, 64) cells, one cell per cycle, then issues the wrap
// edge and waits for the three-stage edge unit to drain. The ring ends each
// query back in its starting order. A query is accepted while an earlier
// result still waits in the output register; the next result waits for it.
// ----------------------------------------------------------------------------
module point_in_polygon_test_top #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   action,
    input  logic [pip_pkg::IDX_W-1:0]              vertex_index,
    input  logic signed [pip_pkg::PORT_COORD_W-1:0] x_coord,
    input  logic signed [pip_pkg::PORT_COORD_W-1:0] y_coord,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   inside_res,
    input  logic                                   cfg_wr_en,
    input  logic [pip_pkg::COUNT_W-1:0]            cfg_wr_data
);

    localparam int W       = COORD_WIDTH;
    localparam int IDX_W   = pip_pkg::IDX_W;
    localparam int COUNT_W = pip_pkg::COUNT_W;
    // Slots beyond the index field can never be written, so no cell backs them.
    localparam int CELLS   = (MAX_VERTICES < pip_pkg::SLOTS) ? MAX_VERTICES
                                                              : pip_pkg::SLOTS;
    localparam int CNT_W   = $clog2(CELLS + 1);

    pip_pkg::state_t state_reg, state_next;

    logic [COUNT_W-1:0]  vertex_count_reg;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic signed [W-1:0] qx_reg, qy_reg;
    logic signed [W-1:0] first_x_reg, first_y_reg;
    logic signed [W-1:0] prev_x_reg, prev_y_reg;
    logic                walk_ok_reg;
    logic                out_valid_reg;
    logic                inside_res_reg;

    logic signed [W-1:0] pt_x, pt_y;
    logic                in_fire, load_fire, query_fire, load_ok;
    logic                inbox;
    logic                shift_en, edge_valid, save_first, out_load;
    logic signed [W-1:0] edge_cur_x, edge_cur_y;
    logic                edge_busy;
    pip_pkg::edge_status_t edge_status;

    logic signed [W-1:0] cell_x [CELLS];
    logic signed [W-1:0] cell_y [CELLS];

    assign pt_x       = x_coord[W-1:0];
    assign pt_y       = y_coord[W-1:0];
    assign in_fire    = in_valid && in_ready;
    assign load_fire  = in_fire && (action == pip_pkg::ACT_LOAD);
    assign query_fire = in_fire && (action == pip_pkg::ACT_QUERY);
    assign load_ok    = ({1'b0, vertex_index} < (IDX_W + 1)'(CELLS));

    assign n_eff = (vertex_count_reg > COUNT_W'(CELLS)) ? CNT_W'(CELLS)
                                                        : CNT_W'(vertex_count_reg);

    // Vertex ring: cell i takes cell i+1, so cell 0 shows vertex k at step k.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        pip_cell #(
            .W (W)
        ) u_cell (
            .clk      (clk),
            .load_en  (load_fire && load_ok && (vertex_index == IDX_W'(i))),
            .load_x   (pt_x),
            .load_y   (pt_y),
            .shift_en (shift_en),
            .next_x   (cell_x[(i + 1) % CELLS]),
            .next_y   (cell_y[(i + 1) % CELLS]),
            .x        (cell_x[i]),
            .y        (cell_y[i])
        );
    end

    pip_bbox #(
        .W (W)
    ) u_bbox (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (load_fire && load_ok),
        .load_first (vertex_index == '0),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .inbox      (inbox)
    );

    pip_edge_unit #(
        .W (W)
    ) u_edge (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (query_fire),
        .edge_valid (edge_valid),
        .prev_x     (prev_x_reg),
        .prev_y     (prev_y_reg),
        .cur_x      (edge_cur_x),
        .cur_y      (edge_cur_y),
        .query_x    (qx_reg),
        .query_y    (qy_reg),
        .busy       (edge_busy),
        .status     (edge_status)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                if (query_fire)
                begin
                    if (inbox && (n_eff != '0))
                        state_next = pip_pkg::ST_WALK;
                    else
                        state_next = pip_pkg::ST_FINISH;
                end
            end
            pip_pkg::ST_WALK:
            begin
                if (k_reg == CNT_W'(CELLS - 1))
                    state_next = pip_pkg::ST_WRAP;
            end
            pip_pkg::ST_WRAP:
            begin
                state_next = pip_pkg::ST_DRAIN;
            end
            pip_pkg::ST_DRAIN:
            begin
                if (!edge_busy)
                    state_next = pip_pkg::ST_FINISH;
            end
            pip_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = pip_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pip_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        shift_en   = 1'b0;
        edge_valid = 1'b0;
        save_first = 1'b0;
        out_load   = 1'b0;
        edge_cur_x = cell_x[0];
        edge_cur_y = cell_y[0];
        unique case (state_reg)
            pip_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            pip_pkg::ST_WALK:
            begin
                shift_en   = 1'b1;
                save_first = (k_reg == '0);
                edge_valid = (k_reg != '0) && (k_reg < n_eff);
            end
            pip_pkg::ST_WRAP:
            begin
                // Closing edge from the last vertex back to vertex 0.
                edge_valid = 1'b1;
                edge_cur_x = first_x_reg;
                edge_cur_y = first_y_reg;
            end
            pip_pkg::ST_DRAIN:
            begin
                edge_valid = 1'b0;
            end
            pip_pkg::ST_FINISH:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        if (query_fire)
            k_next = '0;
        else if (shift_en)
            k_next = CNT_W'(k_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pip_pkg::ST_IDLE;
            vertex_count_reg <= '0;
            k_reg            <= '0;
            walk_ok_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_wr_en)
                vertex_count_reg <= cfg_wr_data;
            if (query_fire)
                walk_ok_reg <= inbox && (n_eff != '0);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            qx_reg <= pt_x;
            qy_reg <= pt_y;
        end
        if (save_first)
        begin
            first_x_reg <= cell_x[0];
            first_y_reg <= cell_y[0];
        end
        // Only the first n_eff vertices are kept, so the wrap step sees the last one.
        if (shift_en && (k_reg < n_eff))
        begin
            prev_x_reg <= cell_x[0];
            prev_y_reg <= cell_y[0];
        end
        // Differing parities mean the point lies on an edge.
        if (out_load)
            inside_res_reg <= walk_ok_reg &&
                              (edge_status.hit || edge_status.right_odd ||
                               edge_status.left_odd);
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_res_reg;

    // The edge pipeline is empty whenever a new item can be taken.
    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pip_pkg::ST_IDLE) |-> !edge_busy)
        else $error("edge unit busy while the block is idle");

    // A full rotation always ends in the closing edge.
    a_walk_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pip_pkg::ST_WALK && k_reg == CNT_W'(CELLS - 1))
        |=> (state_reg == pip_pkg::ST_WRAP))
        else $error("ring walk did not end in the wrap step");

    // A query that skips the walk answers zero.
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !walk_ok_reg) |=> (out_valid_reg && !inside_res_reg))
        else $error("query outside the box produced a nonzero result");

    // Edges are only issued while a walk is under way.
    a_edge_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        edge_valid |-> (state_reg == pip_pkg::ST_WALK || state_reg == pip_pkg::ST_WRAP)
                       && walk_ok_reg)
        else $error("edge issued outside a ring walk");

endmodule
